@@ sv/ssc_pkg.sv @@
package ssc_pkg;

    localparam int NUM_W      = 11;
    localparam int WANT_W     = NUM_W + 1;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    typedef struct packed {
        logic load;
        logic release_num;
        logic pop;
        logic push;
        logic set_fail;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic failed;
        logic last;
        logic num_is_want;
        logic top_is_want;
        logic can_push;
        logic full;
        logic out_free;
    } t_sts;

endpackage

@@ sv/stack_sortability_checker_unit.sv @@
// Checks whether a stream of numbers can be released in ascending order 1, 2, 3, ...
// through one side stack. Each beat on the slave side carries one number; the beat
// with tlast closes the sequence, and one beat on the master side then carries the
// verdict (1 = sortable) while the state clears for the next sequence. Each item is
// loaded in IDLE and evaluated in EVAL; every stack entry it pops adds a pass through
// SETTLE for the registered read of the single stack memory, MAX_ITEMS entries deep,
// and the last item of a sequence waits in FINISH until the master side is free. No new
// number is taken until the previous one is done; after a failure the remaining numbers
// are taken and ignored. The stack memory needs no clearing after reset.
module stack_sortability_checker_unit
    import ssc_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [10:0] car_number
    input  logic                 i_s_axis_tlast,  // is_last
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata   // [0] sortable
);

    t_cmd cmd;
    t_sts sts;
    logic sortable;

    ssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    ssc_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num       (i_s_axis_tdata[NUM_W-1:0]),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_sortable  (sortable)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, sortable};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !sts.full)
        else $error("push onto full stack");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.release_num, cmd.pop, cmd.push, cmd.set_fail, cmd.emit}))
        else $error("conflicting datapath commands");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("verdict overwrites pending beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while busy");

endmodule

@@ sv/ssc_dpath.sv @@
module ssc_dpath
    import ssc_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [NUM_W-1:0] i_num,
    input  logic             i_last,
    input  logic             i_out_ready,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output logic             o_sortable
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DW = $clog2(MAX_ITEMS + 1);

    logic [NUM_W-1:0] r_stack [MAX_ITEMS];
    logic [NUM_W-1:0] r_num;
    logic             r_last;
    logic [NUM_W-1:0] r_top;
    logic [NUM_W-1:0] r_nel;
    logic [DW-1:0]    r_depth;
    logic             r_failed;
    logic             r_out_valid;
    logic             r_sortable;

    logic [WANT_W-1:0] want;
    logic [DW-1:0]     depth_less_one;
    logic              stack_empty;

    assign want           = {1'b0, r_nel} + WANT_W'(1);
    assign depth_less_one = r_depth - DW'(1);
    assign stack_empty    = (r_depth == '0);

    always_comb begin
        o_sts.failed      = r_failed;
        o_sts.last        = r_last;
        o_sts.num_is_want = ({1'b0, r_num} == want);
        o_sts.top_is_want = !stack_empty && ({1'b0, r_top} == want);
        o_sts.can_push    = stack_empty || (r_num < r_top);
        o_sts.full        = (r_depth == DW'(MAX_ITEMS));
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_sortable  = r_sortable;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_depth[AW-1:0]] <= r_num;
        end
        r_top <= r_stack[depth_less_one[AW-1:0]];
        if (i_cmd.load) begin
            r_num  <= i_num;
            r_last <= i_last;
        end
        if (i_cmd.emit) begin
            r_sortable <= !r_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nel       <= '0;
            r_depth     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_nel    <= '0;
                r_depth  <= '0;
                r_failed <= 1'b0;
            end else begin
                if (i_cmd.release_num) begin
                    r_nel <= r_num;
                end
                if (i_cmd.pop) begin
                    r_nel   <= want[NUM_W-1:0];
                    r_depth <= depth_less_one;
                end
                if (i_cmd.push) begin
                    r_depth <= r_depth + DW'(1);
                end
                if (i_cmd.set_fail) begin
                    r_failed <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ sv/ssc_ctrl.sv @@
module ssc_ctrl
    import ssc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SETTLE,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state done_state;

    assign o_in_ready = (r_state == ST_IDLE);
    assign done_state = i_sts.last ? ST_FINISH : ST_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (i_sts.failed) begin
                    n_state = done_state;
                end else if (i_sts.num_is_want) begin
                    o_cmd.release_num = 1'b1;
                    n_state           = done_state;
                end else if (i_sts.top_is_want) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_SETTLE;
                end else if (i_sts.can_push && !i_sts.full) begin
                    o_cmd.push = 1'b1;
                    n_state    = done_state;
                end else begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = done_state;
                end
            end
            ST_SETTLE: begin
                n_state = ST_EVAL;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ssc_pkg::*;

    localparam int STACK_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 900;
    localparam int MAX_REPORTS = 10;

    class verdict_scoreboard;
        logic [NUM_W-1:0]  stack_mem [STACK_DEPTH];
        int unsigned       depth;
        logic [WANT_W-1:0] released;
        bit                failed;
        bit                verdict_q [$];
        int unsigned       mismatches;
        int unsigned       verdicts_checked;
        int unsigned       sortable_seen;

        function new();
            depth = 0;
            released = '0;
            failed = 1'b0;
            mismatches = 0;
            verdicts_checked = 0;
            sortable_seen = 0;
        endfunction

        function void note_car(logic [NUM_W-1:0] num, bit last);
            logic [WANT_W-1:0] want;
            bit                consumed;
            consumed = 1'b0;
            while (!failed && !consumed) begin
                want = released + 1'b1;
                if ({1'b0, num} == want) begin
                    released = want;
                    consumed = 1'b1;
                end else if (depth > 0 && {1'b0, stack_mem[depth-1]} == want) begin
                    released = want;
                    depth--;
                end else if (depth == 0 || num < stack_mem[depth-1]) begin
                    if (depth >= STACK_DEPTH) begin
                        failed = 1'b1;
                    end else begin
                        stack_mem[depth] = num;
                        depth++;
                    end
                    consumed = 1'b1;
                end else begin
                    failed = 1'b1;
                end
            end
            if (last) begin
                verdict_q.push_back(!failed);
                depth = 0;
                released = '0;
                failed = 1'b0;
            end
        endfunction

        function void check_verdict(bit got);
            bit want_sortable;
            verdicts_checked++;
            if (got) begin
                sortable_seen++;
            end
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: verdict sortable=%0b with no sequence closed", got);
                end
            end else begin
                want_sortable = verdict_q.pop_front();
                if (got !== want_sortable) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: verdict %0d sortable expected %0b got %0b",
                                 verdicts_checked, want_sortable, got);
                    end
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;   // [10:0] car_number
    logic                 i_s_axis_tlast;   // is_last
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;   // [0] sortable

    verdict_scoreboard sb = new();
    logic [NUM_W-1:0]  car_q [$];
    bit                s_idle_on = 1'b1;
    bit                m_idle_on = 1'b1;
    int unsigned       beats_sent = 0;
    int unsigned       sequences_sent = 0;
    int unsigned       cycles = 0;

    stack_sortability_checker_unit #(
        .MAX_ITEMS(STACK_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tlast(i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            sb.check_verdict(o_m_axis_tdata[0]);
        end
    end

    initial begin
        int stall;
        forever begin
            stall = m_idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1));
        end
    end

    task automatic send_car(input logic [NUM_W-1:0] num, input bit last);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {{(S_TDATA_W-NUM_W){1'b0}}, num};
        i_s_axis_tlast <= last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_car(num, last);
        beats_sent++;
    endtask

    task automatic play_sequence();
        foreach (car_q[k]) begin
            send_car(car_q[k], k == car_q.size() - 1);
        end
        sequences_sent++;
    endtask

    task automatic wait_for_verdicts();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.verdict_q.size() != 0);
    endtask

    // fill car_q from a random push/pop walk so the stack releases 1..n in order
    task automatic build_sortable(input int n);
        int open_slots [$];
        int pushed;
        int popped;
        car_q = {};
        pushed = 0;
        popped = 0;
        while (popped < n) begin
            if (pushed < n && (open_slots.size() == 0 || $urandom_range(0, 1) == 1)) begin
                car_q.push_back('0);
                open_slots.push_back(pushed);
                pushed++;
            end else begin
                popped++;
                car_q[open_slots.pop_back()] = popped[NUM_W-1:0];
            end
        end
    endtask

    task automatic send_random_sequence();
        int               n;
        int               flavor;
        int               a;
        int               b;
        logic [NUM_W-1:0] swap;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        build_sortable(n);
        flavor = $urandom_range(0, 19);
        if (flavor >= 11 && flavor < 15) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            swap = car_q[a];
            car_q[a] = car_q[b];
            car_q[b] = swap;
        end else if (flavor >= 15 && flavor < 18) begin
            car_q[$urandom_range(0, n - 1)] = NUM_W'($urandom_range(0, 2047));
        end else if (flavor >= 18) begin
            foreach (car_q[k]) begin
                car_q[k] = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 2047))
                                                       : NUM_W'($urandom_range(0, n + 1));
            end
        end
        play_sequence();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tlast <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        car_q = {11'd1};                                play_sequence();
        car_q = {11'd0};                                play_sequence();
        car_q = {11'd2047, 11'd1024, 11'd1, 11'd2};     play_sequence();
        car_q = {11'd2, 11'd3, 11'd1};                  play_sequence();
        car_q = {11'd3, 11'd1, 11'd2};                  play_sequence();
        car_q = {11'd2, 11'd3, 11'd1, 11'd5, 11'd4};    play_sequence();
        car_q = {11'd1, 11'd1};                         play_sequence();
        car_q = {11'd2, 11'd2, 11'd1};                  play_sequence();
        car_q = {11'd5, 11'd4, 11'd3, 11'd2, 11'd1};    play_sequence();
        wait_for_verdicts();

        for (int seq_num = 0; beats_sent < RANDOM_BEATS; seq_num++) begin
            if ($urandom_range(0, 7) == 0) begin
                s_idle_on = $urandom_range(0, 3) != 0;
                m_idle_on = $urandom_range(0, 3) != 0;
            end
            send_random_sequence();
            if ($urandom_range(0, 11) == 0) begin
                wait_for_verdicts();
            end
        end

        wait_for_verdicts();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d sequences in %0d beats; %0d verdicts compared, %0d sortable.",
                 sequences_sent, beats_sent, sb.verdicts_checked, sb.sortable_seen);
        $display("Covered deep pops, repeats, zeros, out-of-range numbers and output stalls.");
        if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("ERROR: %0d mismatches, %0d verdicts missing",
                     sb.mismatches, sb.verdict_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ssc_pkg.sv
sv/ssc_dpath.sv
sv/ssc_ctrl.sv
sv/stack_sortability_checker_unit.sv
test/tb_top.sv
